### rtl/gddn_pkg.sv
// Shared widths, constants and small lookup functions for the date to day number block.
`timescale 1ns / 1ps
`default_nettype none
package gddn_pkg;

	// Field widths
	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int HOUR_W  = 5;
	localparam int MIN_W   = 6;
	localparam int SEC_W   = 6;
	localparam int JDN_W   = 23;
	localparam int WDAY_W  = 3;

	// Internal widths
	localparam int YADJ_W  = 15;  // year + 4800, at most 21183
	localparam int MOFF_W  = 9;   // cumulative month offset, at most 367
	localparam int Q100_W  = 8;   // quotient by 100, at most 211

	// Day number formula
	localparam int YEAR_SHIFT    = 4800;
	localparam int DAYS_PER_YEAR = 365;
	localparam int JDN_OFFSET    = 32045;

	// Division by 100 as multiply by reciprocal and shift; exact below 2**15
	localparam int DIV100_MUL = 20972;
	localparam int DIV100_SH  = 21;
	localparam int CENTURY    = 100;

	// Time of day limits
	localparam int HOURS_PER_DAY = 24;
	localparam int MINS_PER_HOUR = 60;

	// Month numbers with special lengths
	localparam logic [MONTH_W-1:0] FEB = 4'd2;
	localparam logic [MONTH_W-1:0] APR = 4'd4;
	localparam logic [MONTH_W-1:0] JUN = 4'd6;
	localparam logic [MONTH_W-1:0] SEP = 4'd9;
	localparam logic [MONTH_W-1:0] NOV = 4'd11;
	localparam logic [MONTH_W-1:0] DEC = 4'd12;

	// Bounds of the day number over all field values, and of any valid date
	localparam int JDN_MIN       = 1721028;
	localparam int JDN_MAX       = 7705284;
	localparam int JDN_MIN_VALID = 1721426;

	// Pipeline advance strobes shared between the top level and the date units
	typedef struct packed {
		logic ld_s2;
		logic ld_s3;
		logic ld_s4;
	} gddn_adv_t;

	// Days before the first of the month, counted from March 1.
	// January and February (and month zero) belong to the previous year.
	function automatic logic [MOFF_W-1:0] month_offset(input logic [MONTH_W-1:0] month);
		logic [MOFF_W-1:0] r;
		unique case (month)
			4'd0:  r = 9'd275;
			4'd1:  r = 9'd306;
			4'd2:  r = 9'd337;
			4'd3:  r = 9'd0;
			4'd4:  r = 9'd31;
			4'd5:  r = 9'd61;
			4'd6:  r = 9'd92;
			4'd7:  r = 9'd122;
			4'd8:  r = 9'd153;
			4'd9:  r = 9'd184;
			4'd10: r = 9'd214;
			4'd11: r = 9'd245;
			4'd12: r = 9'd275;
			4'd13: r = 9'd306;
			4'd14: r = 9'd337;
			4'd15: r = 9'd367;
		endcase
		return r;
	endfunction

	function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] month,
		input logic leap);
		logic [DAY_W-1:0] r;
		unique case (month)
			FEB:                r = leap ? 5'd29 : 5'd28;
			APR, JUN, SEP, NOV: r = 5'd30;
			default:            r = 5'd31;
		endcase
		return r;
	endfunction

	// Remainder by 7: since 8 mod 7 is 1, octal digits are summed and folded.
	function automatic logic [WDAY_W-1:0] mod7(input logic [JDN_W-1:0] v);
		logic [JDN_W:0] w;
		logic [5:0]     s;
		logic [3:0]     t;
		logic [3:0]     u;
		w = {1'b0, v};
		s = '0;
		for (int i = 0; i < 8; i++) begin
			s = s + 6'(w[3*i +: 3]);
		end
		t = 4'(s[5:3]) + 4'(s[2:0]);
		u = 4'(t[3]) + 4'(t[2:0]);
		if (u >= 4'd7) begin
			u = u - 4'd7;
		end
		return u[WDAY_W-1:0];
	endfunction

endpackage
`default_nettype wire

### rtl/gddn_if.sv
// Handshake channel interfaces for the date input and the result output.
`timescale 1ns / 1ps
`default_nettype none
interface gddn_in_if;
	import gddn_pkg::*;
	logic               valid;
	logic               ready;
	logic [YEAR_W-1:0]  year;
	logic [MONTH_W-1:0] month;
	logic [DAY_W-1:0]   day;
	logic [HOUR_W-1:0]  hour;
	logic [MIN_W-1:0]   minute;
	logic [SEC_W-1:0]   second;
	logic [YEAR_W-1:0]  other_year;
	logic [MONTH_W-1:0] other_month;
	logic [DAY_W-1:0]   other_day;

	modport source (output valid, year, month, day, hour, minute, second,
		other_year, other_month, other_day, input ready);
	modport sink (input valid, year, month, day, hour, minute, second,
		other_year, other_month, other_day, output ready);
endinterface

interface gddn_out_if;
	import gddn_pkg::*;
	logic              valid;
	logic              ready;
	logic              valid_res;
	logic              other_valid;
	logic [JDN_W-1:0]  day_number;
	logic [WDAY_W-1:0] weekday;
	logic [JDN_W-1:0]  day_difference;

	modport source (output valid, valid_res, other_valid, day_number, weekday,
		day_difference, input ready);
	modport sink (input valid, valid_res, other_valid, day_number, weekday,
		day_difference, output ready);
endinterface
`default_nettype wire

### rtl/gddn_date.sv
// Three-stage day number and validity datapath for one calendar date.
`timescale 1ns / 1ps
`default_nettype none
module gddn_date (
	input  wire                              clk,
	input  wire gddn_pkg::gddn_adv_t         adv,
	input  wire [gddn_pkg::YEAR_W-1:0]       year,
	input  wire [gddn_pkg::MONTH_W-1:0]      month,
	input  wire [gddn_pkg::DAY_W-1:0]        day,
	input  wire                              extra_ok,
	output logic [gddn_pkg::JDN_W-1:0]       jdn,
	output logic                             ok
);
	import gddn_pkg::*;

	// Stage 2: shifted year, month offset, quotient of the raw year by 100
	logic [YADJ_W-1:0]  yadj_s2;
	logic [MOFF_W-1:0]  moff_s2;
	logic [DAY_W-1:0]   day_s2;
	logic [YEAR_W-1:0]  year_s2;
	logic [MONTH_W-1:0] month_s2;
	logic [Q100_W-1:0]  qyr_s2;
	logic               pre_ok_s2;

	// Stage 3: partial sum and century count of the shifted year
	logic [JDN_W-1:0]   base_s3;
	logic [Q100_W-1:0]  q100_s3;
	logic               ok_s3;

	// Stage 4: finished day number
	logic [JDN_W-1:0]   jdn_s4;
	logic               ok_s4;

	logic               early;
	logic [YADJ_W-1:0]  yadj;
	logic [28:0]        qyr_prod;
	logic [29:0]        q100_prod;
	logic [Q100_W-1:0]  q100_times;
	logic [YEAR_W-1:0]  century_back;
	logic               leap;
	logic [JDN_W-1:0]   base;

	assign early    = (month <= FEB);
	assign yadj     = {1'b0, year} + YADJ_W'(YEAR_SHIFT) - YADJ_W'(early);
	assign qyr_prod = 29'(year) * 29'(DIV100_MUL);

	always_ff @(posedge clk) begin
		if (adv.ld_s2) begin
			yadj_s2   <= yadj;
			moff_s2   <= month_offset(month);
			day_s2    <= day;
			year_s2   <= year;
			month_s2  <= month;
			qyr_s2    <= qyr_prod[DIV100_SH +: Q100_W];
			pre_ok_s2 <= (year != '0) && (month != '0) && (month <= DEC) &&
				(day != '0) && extra_ok;
		end
	end

	// Leap year: divisible by 4, and either not by 100 or also by 400
	assign century_back = YEAR_W'(qyr_s2 * 14'(CENTURY));
	assign leap = (year_s2[1:0] == 2'b00) &&
		((century_back != year_s2) || (qyr_s2[1:0] == 2'b00));
	assign q100_prod = 30'(yadj_s2) * 30'(DIV100_MUL);
	assign base = JDN_W'(day_s2) + JDN_W'(moff_s2) +
		JDN_W'(yadj_s2) * JDN_W'(DAYS_PER_YEAR) + JDN_W'(yadj_s2 >> 2);

	always_ff @(posedge clk) begin
		if (adv.ld_s3) begin
			base_s3 <= base;
			q100_s3 <= q100_prod[DIV100_SH +: Q100_W];
			ok_s3   <= pre_ok_s2 && (day_s2 <= month_length(month_s2, leap));
		end
	end

	assign q100_times = q100_s3 >> 2;

	always_ff @(posedge clk) begin
		if (adv.ld_s4) begin
			jdn_s4 <= base_s3 - JDN_W'(q100_s3) + JDN_W'(q100_times) - JDN_W'(JDN_OFFSET);
			ok_s4  <= ok_s3;
		end
	end

	assign jdn = jdn_s4;
	assign ok  = ok_s4;

endmodule
`default_nettype wire

### rtl/gregorian_date_to_day_number.sv
// Top level: Gregorian date to Julian day number, weekday and day difference.
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Interface    Contents
// date_in   sink       gddn_in_if   first date with time of day, second date
// date_out  source     gddn_out_if  validity flags, day number, weekday, difference
//
// Each transaction passes five register stages: input register, three stages in the
// date units (shifted year and month offset, partial sum with the multiply by the
// reciprocal of 100, finished day number), and the result register that holds the
// weekday and the difference. One transaction is taken per cycle while date_out keeps taking results.
// Every stage advances whenever the next one is empty or moving, so bubbles close up and
// a new date is accepted while a finished result still waits on date_out.
// Reset clears only the stage valid flags; the data registers load without reset.
module gregorian_date_to_day_number (
	input  wire        clk,
	input  wire        arst_n,
	gddn_in_if.sink    date_in,
	gddn_out_if.source date_out
);
	import gddn_pkg::*;

	// Stage valid flags
	logic vld_s1;
	logic vld_s2;
	logic vld_s3;
	logic vld_s4;
	logic vld_s5;

	// A stage can take new data when it is empty or its content leaves this cycle.
	logic rdy_s1;
	logic rdy_s2;
	logic rdy_s3;
	logic rdy_s4;
	logic rdy_s5;
	logic ld_s1;
	logic ld_s5;
	gddn_adv_t adv;

	assign rdy_s5 = !vld_s5 || date_out.ready;
	assign rdy_s4 = !vld_s4 || rdy_s5;
	assign rdy_s3 = !vld_s3 || rdy_s4;
	assign rdy_s2 = !vld_s2 || rdy_s3;
	assign rdy_s1 = !vld_s1 || rdy_s2;

	assign date_in.ready = rdy_s1;
	assign ld_s1     = date_in.valid && rdy_s1;
	assign adv.ld_s2 = vld_s1 && rdy_s2;
	assign adv.ld_s3 = vld_s2 && rdy_s3;
	assign adv.ld_s4 = vld_s3 && rdy_s4;
	assign ld_s5     = vld_s4 && rdy_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= ld_s1     || (vld_s1 && !rdy_s2);
			vld_s2 <= adv.ld_s2 || (vld_s2 && !rdy_s3);
			vld_s3 <= adv.ld_s3 || (vld_s3 && !rdy_s4);
			vld_s4 <= adv.ld_s4 || (vld_s4 && !rdy_s5);
			vld_s5 <= ld_s5     || (vld_s5 && !date_out.ready);
		end
	end

	// Input register
	logic [YEAR_W-1:0]  year_s1;
	logic [MONTH_W-1:0] month_s1;
	logic [DAY_W-1:0]   day_s1;
	logic [HOUR_W-1:0]  hour_s1;
	logic [MIN_W-1:0]   minute_s1;
	logic [SEC_W-1:0]   second_s1;
	logic [YEAR_W-1:0]  oyear_s1;
	logic [MONTH_W-1:0] omonth_s1;
	logic [DAY_W-1:0]   oday_s1;

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			year_s1   <= date_in.year;
			month_s1  <= date_in.month;
			day_s1    <= date_in.day;
			hour_s1   <= date_in.hour;
			minute_s1 <= date_in.minute;
			second_s1 <= date_in.second;
			oyear_s1  <= date_in.other_year;
			omonth_s1 <= date_in.other_month;
			oday_s1   <= date_in.other_day;
		end
	end

	// The time of day only gates the validity flag of the first date.
	logic time_ok;
	assign time_ok = (hour_s1 < HOUR_W'(HOURS_PER_DAY)) &&
		(minute_s1 < MIN_W'(MINS_PER_HOUR)) && (second_s1 < SEC_W'(MINS_PER_HOUR));

	logic [JDN_W-1:0] jdn_a;
	logic [JDN_W-1:0] jdn_b;
	logic             ok_a;
	logic             ok_b;

	gddn_date u_date_a (
		.clk      (clk),
		.adv      (adv),
		.year     (year_s1),
		.month    (month_s1),
		.day      (day_s1),
		.extra_ok (time_ok),
		.jdn      (jdn_a),
		.ok       (ok_a)
	);

	gddn_date u_date_b (
		.clk      (clk),
		.adv      (adv),
		.year     (oyear_s1),
		.month    (omonth_s1),
		.day      (oday_s1),
		.extra_ok (1'b1),
		.jdn      (jdn_b),
		.ok       (ok_b)
	);

	// Result register: weekday by octal digit folding, absolute difference
	logic              valid_res_s5;
	logic              other_valid_s5;
	logic [JDN_W-1:0]  jdn_s5;
	logic [WDAY_W-1:0] wday_s5;
	logic [JDN_W-1:0]  diff_s5;

	always_ff @(posedge clk) begin
		if (ld_s5) begin
			valid_res_s5   <= ok_a;
			other_valid_s5 <= ok_b;
			jdn_s5         <= jdn_a;
			wday_s5        <= mod7(jdn_a);
			diff_s5        <= (jdn_a > jdn_b) ? (jdn_a - jdn_b) : (jdn_b - jdn_a);
		end
	end

	assign date_out.valid          = vld_s5;
	assign date_out.valid_res      = valid_res_s5;
	assign date_out.other_valid    = other_valid_s5;
	assign date_out.day_number     = jdn_s5;
	assign date_out.weekday        = wday_s5;
	assign date_out.day_difference = diff_s5;

	// A valid first date can never precede January 1 of year 1.
	a_valid_jdn_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(date_out.valid && date_out.valid_res) |->
			(date_out.day_number >= JDN_W'(JDN_MIN_VALID)))
		else $error("valid date gave a day number below year 1");

	// Any field values keep the day number inside the reachable span.
	a_jdn_span: assert property (@(posedge clk) disable iff (!arst_n)
		date_out.valid |-> ((date_out.day_number >= JDN_W'(JDN_MIN)) &&
			(date_out.day_number <= JDN_W'(JDN_MAX))))
		else $error("day number outside reachable span");

	a_weekday_range: assert property (@(posedge clk) disable iff (!arst_n)
		date_out.valid |-> (date_out.weekday != 3'd7))
		else $error("weekday fold left an unreduced remainder");

	a_diff_span: assert property (@(posedge clk) disable iff (!arst_n)
		date_out.valid |-> (date_out.day_difference <= JDN_W'(JDN_MAX - JDN_MIN)))
		else $error("day difference larger than the reachable span");

endmodule
`default_nettype wire

### dv/gddn_result_checker.sv
// Checker that predicts every date conversion and compares it with the block's results.
`timescale 1ns / 1ps
module gddn_result_checker (
	input  wire clk,
	input  wire arst_n,
	gddn_in_if  date_in,
	gddn_out_if date_out,
	output int  mismatches,
	output int  outstanding
);
	import gddn_pkg::*;

	typedef struct packed {
		logic              valid_res;
		logic              other_valid;
		logic [JDN_W-1:0]  day_number;
		logic [WDAY_W-1:0] weekday;
		logic [JDN_W-1:0]  day_difference;
	} day_result_t;

	day_result_t expected_q[$];
	int          err_count;

	function automatic bit is_leap_year(input int unsigned y);
		return ((y % 4) == 0 && (y % CENTURY) != 0) || (y % 400) == 0;
	endfunction

	function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
		if (m == FEB) begin
			return is_leap_year(y) ? 29 : 28;
		end
		if (m == APR || m == JUN || m == SEP || m == NOV) begin
			return 30;
		end
		return 31;
	endfunction

	function automatic bit date_is_valid(input int unsigned y, input int unsigned m,
		input int unsigned d);
		return y >= 1 && m >= 1 && m <= DEC && d >= 1 && d <= days_in_month(m, y);
	endfunction

	// Months 0 to 2 count as the tail of the previous year, so the year starts in March.
	function automatic int unsigned day_count(input int unsigned y, input int unsigned m,
		input int unsigned d);
		int unsigned early;
		int unsigned ys;
		int unsigned ms;
		early = (m <= 2) ? 1 : 0;
		ys = y + YEAR_SHIFT - early;
		ms = m + 12 * early - 3;
		return d + (153 * ms + 2) / 5 + DAYS_PER_YEAR * ys + ys / 4 - ys / CENTURY
			+ ys / 400 - JDN_OFFSET;
	endfunction

	function automatic day_result_t predict_result(
		input logic [YEAR_W-1:0] y, input logic [MONTH_W-1:0] m, input logic [DAY_W-1:0] d,
		input logic [HOUR_W-1:0] hh, input logic [MIN_W-1:0] mi, input logic [SEC_W-1:0] ss,
		input logic [YEAR_W-1:0] oy, input logic [MONTH_W-1:0] om,
		input logic [DAY_W-1:0] od);
		day_result_t r;
		int unsigned first_day;
		int unsigned second_day;
		first_day  = day_count(y, m, d);
		second_day = day_count(oy, om, od);
		r.valid_res = date_is_valid(y, m, d) && hh < HOURS_PER_DAY && mi < MINS_PER_HOUR
			&& ss < MINS_PER_HOUR;
		r.other_valid    = date_is_valid(oy, om, od);
		r.day_number     = JDN_W'(first_day);
		r.weekday        = WDAY_W'(first_day % 7);
		r.day_difference = JDN_W'((first_day > second_day) ? first_day - second_day
			: second_day - first_day);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		day_result_t want;
		day_result_t got;
		if (!arst_n) begin
			expected_q.delete();
			err_count = 0;
		end else begin
			if (date_out.valid && date_out.ready) begin
				got = '{date_out.valid_res, date_out.other_valid, date_out.day_number,
					date_out.weekday, date_out.day_difference};
				if (expected_q.size() == 0) begin
					if (err_count < 10) begin
						$display("%0t: unexpected result valid=%0d other=%0d",
							$realtime, got.valid_res, got.other_valid,
							" jdn=%0d wd=%0d diff=%0d", got.day_number,
							got.weekday, got.day_difference);
					end
					err_count++;
				end else begin
					want = expected_q.pop_front();
					if (got !== want) begin
						if (err_count < 10) begin
							$display("%0t: mismatch (expected/actual) valid %0d/%0d",
								$realtime, want.valid_res, got.valid_res,
								" other %0d/%0d jdn %0d/%0d", want.other_valid,
								got.other_valid, want.day_number, got.day_number,
								" wd %0d/%0d diff %0d/%0d", want.weekday, got.weekday,
								want.day_difference, got.day_difference);
						end
						err_count++;
					end
				end
			end
			if (date_in.valid && date_in.ready) begin
				expected_q.push_back(predict_result(date_in.year, date_in.month, date_in.day,
					date_in.hour, date_in.minute, date_in.second, date_in.other_year,
					date_in.other_month, date_in.other_day));
			end
		end
		mismatches  <= err_count;
		outstanding <= expected_q.size();
	end

endmodule

### dv/gregorian_date_to_day_number_test.sv
// Top of the date to day number testbench: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 1ps
module gregorian_date_to_day_number_test;
	import gddn_pkg::*;

	// One input transaction: a dated time of day plus a second date for the difference.
	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic [HOUR_W-1:0]  hour;
		logic [MIN_W-1:0]   minute;
		logic [SEC_W-1:0]   second;
		logic [YEAR_W-1:0]  other_year;
		logic [MONTH_W-1:0] other_month;
		logic [DAY_W-1:0]   other_day;
	} date_pair_t;

	// The pipeline is five stages deep, so a hold of this length backs it up well past full.
	localparam int HOLD_CYCLES   = 40;
	localparam int DRAIN_CYCLES  = 10;
	localparam int ITEMS_PER_RUN = 476;
	localparam int PAIR_W        = $bits(date_pair_t);

	logic clk;
	logic arst_n;
	int   mismatches;
	int   outstanding;
	int   src_idle_pct;
	int   sink_idle_pct;
	bit   long_hold_req;

	gddn_in_if  date_in();
	gddn_out_if date_out();

	gregorian_date_to_day_number u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.date_in  (date_in),
		.date_out (date_out)
	);

	// The checker watches both channels on its own and reports how many results went
	// wrong and how many are still in flight.
	gddn_result_checker u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.date_in     (date_in),
		.date_out    (date_out),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs: the slowest legal run needs well under a tenth
	// of this.
	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic date_pair_t make_date(input int y, input int m, input int d,
		input int hh, input int mi, input int ss, input int oy, input int om, input int od);
		date_pair_t p;
		p.year        = YEAR_W'(y);
		p.month       = MONTH_W'(m);
		p.day         = DAY_W'(d);
		p.hour        = HOUR_W'(hh);
		p.minute      = MIN_W'(mi);
		p.second      = SEC_W'(ss);
		p.other_year  = YEAR_W'(oy);
		p.other_month = MONTH_W'(om);
		p.other_day   = DAY_W'(od);
		return p;
	endfunction

	// Years are weighted toward the ends of the range and toward the century and
	// four-century boundaries, where the leap rule changes.
	function automatic int pick_year();
		case ($urandom_range(9))
			0:       return $urandom_range(1, 3);
			1:       return $urandom_range(16380, 16383);
			2:       return 400 * $urandom_range(1, 40);
			3:       return 100 * $urandom_range(1, 163);
			default: return $urandom_range(1, 16383);
		endcase
	endfunction

	// Most transactions are plausible dates, where the validity checks have something to
	// decide; a day up to 31 in every month lets month lengths and leap days go either way.
	// The rest is raw noise over the full field widths.
	function automatic date_pair_t random_date();
		date_pair_t p;
		if ($urandom_range(99) < 80) begin
			p = make_date(pick_year(), $urandom_range(1, 12),
				($urandom_range(3) == 0) ? $urandom_range(1, 31) : $urandom_range(1, 28),
				$urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59),
				pick_year(), $urandom_range(1, 12),
				($urandom_range(3) == 0) ? $urandom_range(1, 31) : $urandom_range(1, 28));
		end else begin
			p = date_pair_t'(PAIR_W'({$urandom(), $urandom()}));
		end
		return p;
	endfunction

	// Offer one transaction and wait until the block takes it. Idle cycles are inserted
	// before the offer; valid stays high from one transaction to the next otherwise.
	task automatic offer_date(input date_pair_t p);
		while ($urandom_range(99) < src_idle_pct) begin
			date_in.valid <= 1'b0;
			@(posedge clk);
		end
		date_in.valid       <= 1'b1;
		date_in.year        <= p.year;
		date_in.month       <= p.month;
		date_in.day         <= p.day;
		date_in.hour        <= p.hour;
		date_in.minute      <= p.minute;
		date_in.second      <= p.second;
		date_in.other_year  <= p.other_year;
		date_in.other_month <= p.other_month;
		date_in.other_day   <= p.other_day;
		@(posedge clk);
		while (!date_in.ready) begin
			@(posedge clk);
		end
	endtask

	// Receiver side. A long hold-off, when requested, keeps ready low for a counted
	// stretch so that the pipeline fills and the block has to stall its input.
	initial begin
		date_out.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				date_out.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			date_out.ready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	initial begin
		date_pair_t directed_q[$];
		date_in.valid       <= 1'b0;
		date_in.year        <= '0;
		date_in.month       <= '0;
		date_in.day         <= '0;
		date_in.hour        <= '0;
		date_in.minute      <= '0;
		date_in.second      <= '0;
		date_in.other_year  <= '0;
		date_in.other_month <= '0;
		date_in.other_day   <= '0;
		arst_n              <= 1'b0;
		long_hold_req       = 1'b0;
		src_idle_pct        = 20;
		sink_idle_pct       = 75;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed dates. The all-zero and all-ones fields give the smallest and largest
		// day numbers, and together the largest difference.
		directed_q.push_back(make_date(2000, 1, 1, 12, 0, 0, 2000, 1, 1));
		directed_q.push_back(make_date(0, 0, 0, 0, 0, 0, 16383, 15, 31));
		directed_q.push_back(make_date(16383, 15, 31, 31, 63, 63, 0, 0, 0));
		directed_q.push_back(make_date(1, 1, 1, 0, 0, 0, 16383, 12, 31));
		directed_q.push_back(make_date(16383, 12, 31, 23, 59, 59, 1, 1, 1));
		// Leap days: a four-century year is leap, a plain century year is not.
		directed_q.push_back(make_date(2000, 2, 29, 8, 30, 0, 1900, 2, 29));
		directed_q.push_back(make_date(1900, 2, 29, 8, 30, 0, 2000, 2, 29));
		directed_q.push_back(make_date(2024, 2, 29, 1, 1, 1, 2023, 2, 29));
		directed_q.push_back(make_date(2023, 2, 28, 1, 1, 1, 2023, 3, 1));
		// Month lengths, day zero and months outside 1 to 12.
		directed_q.push_back(make_date(2023, 4, 31, 10, 0, 0, 2023, 4, 30));
		directed_q.push_back(make_date(2023, 7, 31, 10, 0, 0, 2023, 6, 31));
		directed_q.push_back(make_date(2023, 5, 0, 10, 0, 0, 2023, 0, 15));
		directed_q.push_back(make_date(2023, 13, 1, 10, 0, 0, 2023, 14, 30));
		directed_q.push_back(make_date(2023, 0, 10, 10, 0, 0, 2023, 15, 10));
		// Time of day on both sides of each limit.
		directed_q.push_back(make_date(2023, 6, 15, 24, 0, 0, 2023, 6, 15));
		directed_q.push_back(make_date(2023, 6, 15, 23, 60, 0, 2023, 6, 15));
		directed_q.push_back(make_date(2023, 6, 15, 23, 59, 60, 2023, 6, 15));
		directed_q.push_back(make_date(2023, 6, 15, 31, 63, 63, 0, 6, 15));
		// Neighbouring days across the March year boundary and a whole year apart.
		directed_q.push_back(make_date(2024, 3, 1, 0, 0, 0, 2024, 2, 29));
		directed_q.push_back(make_date(2024, 12, 31, 0, 0, 0, 2024, 1, 1));
		directed_q.push_back(make_date(2, 2, 28, 0, 0, 0, 1, 12, 31));
		foreach (directed_q[i]) begin
			offer_date(directed_q[i]);
		end

		// Sender idles a little, receiver a lot.
		repeat (ITEMS_PER_RUN) offer_date(random_date());

		// Roles swapped: sender idles a lot, receiver a little.
		src_idle_pct  = 75;
		sink_idle_pct = 20;
		repeat (ITEMS_PER_RUN) offer_date(random_date());

		// Full speed, opened by a long receiver hold-off while transactions keep coming.
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		long_hold_req = 1'b1;
		repeat (ITEMS_PER_RUN) offer_date(random_date());
		date_in.valid <= 1'b0;

		// The checker's count is registered, so start polling after the next edge.
		@(posedge clk);
		while (outstanding != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
